/* rtl/hck_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hck_pkg: shared types and constants for the 2-D Hilbert curve key block
// Point and item types, corner codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package hck_pkg;

    localparam int COORD_W  = 32;
    localparam int KEY_BITS = 33;
    localparam int CFG_IDX_W = 2;

    // corner codes, also the two key bits each level adds
    localparam logic [1:0] CA = 2'd0;
    localparam logic [1:0] CB = 2'd1;
    localparam logic [1:0] CC = 2'd2;
    localparam logic [1:0] CD = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MAX = 2'd3;

    // reset values of the domain edges
    localparam logic signed [COORD_W-1:0] RST_X_MIN = 32'sh0000_0000;
    localparam logic signed [COORD_W-1:0] RST_X_MAX = 32'sh0168_0000;
    localparam logic signed [COORD_W-1:0] RST_Y_MIN = 32'shFFA6_0000;
    localparam logic signed [COORD_W-1:0] RST_Y_MAX = 32'sh005A_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pt;

    // one word in flight between cells
    typedef struct packed {
        logic      vld;
        t_pt       pt;
        t_pt [3:0] box;
    } t_item;

    // floor((a + b) / 2) from the exact 33-bit sum
    function automatic logic signed [COORD_W-1:0] f_mid(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    function automatic t_pt f_pmid(input t_pt a, input t_pt b);
        t_pt r;
        r.x = f_mid(a.x, b.x);
        r.y = f_mid(a.y, b.y);
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/hck_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hck_if: channel interfaces of the Hilbert curve key block
// Point input channel, key output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface hck_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface hck_key_if;
    logic        valid;
    logic        ready;
    logic [32:0] curve_key;
    modport source (output valid, output curve_key, input ready);
    modport sink   (input valid, input curve_key, output ready);
endinterface

interface hck_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/hilbert_curve_key_2d.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one point per cycle; each level is a three-stage cell (magnitudes,
// 32x32 squares, 65-bit sum with nearest-corner pick), the whole chain stalls together.
// Reset: synchronous active low; clears all valid bits and loads the default domain.
// ----------------------------------------------------------------------------
// hilbert_curve_key_2d: Hilbert curve key of a point over a two-square domain
// Head cell picks the half, a chain of LEVELS cells refines the box.
// ----------------------------------------------------------------------------
module hilbert_curve_key_2d
    import hck_pkg::*;
#(
    parameter int LEVELS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hck_point_if.sink  i_point,
    hck_cfg_if.sink    i_cfg,
    hck_key_if.source  o_key
);

    localparam int KEY_W = 2 * LEVELS + 1;

    t_item            w_item [LEVELS+1];
    logic [KEY_W-1:0] w_key  [LEVELS+1];
    logic             w_en;

    // advance the whole chain unless the output word is held
    assign w_en = !w_item[LEVELS].vld || o_key.ready;

    hck_head #(.KEY_W(KEY_W)) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_point (i_point),
        .i_cfg   (i_cfg),
        .o_item  (w_item[0]),
        .o_key   (w_key[0])
    );

    for (genvar g = 0; g < LEVELS; g++) begin : g_cell
        hck_cell #(.KEY_W(KEY_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_item  (w_item[g]),
            .i_key   (w_key[g]),
            .o_item  (w_item[g+1]),
            .o_key   (w_key[g+1])
        );
    end

    // last cell stage is the output register
    assign o_key.valid     = w_item[LEVELS].vld;
    assign o_key.curve_key = KEY_BITS'(w_key[LEVELS]);

    // held output word blocks new points
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key.valid && !o_key.ready |-> !i_point.ready)
        else $error("point accepted while output stalled");

    // held output word stays unchanged
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_key.valid && !o_key.ready |=> o_key.valid && $stable(o_key.curve_key))
        else $error("stalled key word changed");

    // a point enters only while the output side can move
    a_in_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_point.valid && i_point.ready |-> !o_key.valid || o_key.ready)
        else $error("point accepted while chain held");

endmodule
`default_nettype wire

/* rtl/hck_head.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hck_head: domain registers, input register and half selection
// Holds the domain edges, registers the point and builds the first box.
// ----------------------------------------------------------------------------
module hck_head
    import hck_pkg::*;
#(
    parameter int KEY_W = 33
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    hck_point_if.sink        i_point,
    hck_cfg_if.sink          i_cfg,
    output t_item            o_item,
    output logic [KEY_W-1:0] o_key
);

    logic signed [COORD_W-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic signed [COORD_W-1:0] r_xmid;
    logic                      r_in_vld;
    t_pt                       r_in_pt;
    t_item                     r_item;
    logic [KEY_W-1:0]          r_key;
    t_item                     n_item;
    logic                      w_right;

    // accept points only out of reset and while the pipe moves; config words always
    assign i_point.ready = i_en & i_rst_n;
    assign i_cfg.ready   = 1'b1;

    // write domain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= RST_X_MIN;
            r_x_max <= RST_X_MAX;
            r_y_min <= RST_Y_MIN;
            r_y_max <= RST_Y_MAX;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_X_MIN: r_x_min <= i_cfg.data;
                CFG_X_MAX: r_x_max <= i_cfg.data;
                CFG_Y_MIN: r_y_min <= i_cfg.data;
                CFG_Y_MAX: r_y_max <= i_cfg.data;
                default:   r_x_min <= r_x_min;
            endcase
        end
    end

    // track the midline, registered from the domain edges
    always_ff @(posedge i_clk) begin
        r_xmid <= f_mid(r_x_min, r_x_max);
    end

    // capture the point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_en) begin
            r_in_vld <= i_point.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_pt.x <= i_point.x_coord;
            r_in_pt.y <= i_point.y_coord;
        end
    end

    // pick the half and build its box
    always_comb begin
        w_right         = (r_in_pt.x >= r_xmid);
        n_item.vld      = r_in_vld;
        n_item.pt       = r_in_pt;
        n_item.box[CA]  = '{x: r_x_min, y: r_y_max};
        n_item.box[CB]  = '{x: r_x_min, y: r_y_min};
        n_item.box[CC]  = '{x: r_x_max, y: r_y_min};
        n_item.box[CD]  = '{x: r_x_max, y: r_y_max};
        if (w_right) begin
            n_item.box[CA].x = r_xmid;
            n_item.box[CB].x = r_xmid;
        end else begin
            n_item.box[CC].x = r_xmid;
            n_item.box[CD].x = r_xmid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else if (i_en) begin
            r_item.vld <= n_item.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.pt  <= n_item.pt;
            r_item.box <= n_item.box;
            r_key      <= KEY_W'(w_right);
        end
    end

    assign o_item = r_item;
    assign o_key  = r_key;

endmodule
`default_nettype wire

/* rtl/hck_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hck_cell: one refinement level of the Hilbert curve key
// Three stages: distance magnitudes, squares, nearest corner and new box.
// ----------------------------------------------------------------------------
module hck_cell
    import hck_pkg::*;
#(
    parameter int KEY_W = 33
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_en,
    input  t_item            i_item,
    input  wire [KEY_W-1:0]  i_key,
    output t_item            o_item,
    output logic [KEY_W-1:0] o_key
);

    // stage A: coordinate distance magnitudes
    t_item            r_a_item;
    logic [KEY_W-1:0] r_a_key;
    logic [31:0]      r_a_mag [8];
    logic [31:0]      n_a_mag [8];

    // stage B: squares
    t_item            r_b_item;
    logic [KEY_W-1:0] r_b_key;
    logic [63:0]      r_b_sq [8];

    // stage C: refined box
    t_item            r_c_item;
    logic [KEY_W-1:0] r_c_key;

    logic [64:0]      w_dist [4];
    logic [1:0]       w_q;
    t_pt              w_ab, w_ac, w_ad, w_bc, w_bd, w_cd;
    t_pt [3:0]        n_box;

    // find |p - corner| per axis
    always_comb begin
        logic signed [32:0] dx, dy;
        logic [32:0]        mx, my;
        for (int i = 0; i < 4; i++) begin
            dx = {i_item.pt.x[31], i_item.pt.x} - {i_item.box[i].x[31], i_item.box[i].x};
            dy = {i_item.pt.y[31], i_item.pt.y} - {i_item.box[i].y[31], i_item.box[i].y};
            mx = dx[32] ? 33'(-dx) : 33'(dx);
            my = dy[32] ? 33'(-dy) : 33'(dy);
            n_a_mag[2*i]   = mx[31:0];
            n_a_mag[2*i+1] = my[31:0];
        end
    end

    // advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_item.vld <= 1'b0;
            r_b_item.vld <= 1'b0;
            r_c_item.vld <= 1'b0;
        end else if (i_en) begin
            r_a_item.vld <= i_item.vld;
            r_b_item.vld <= r_a_item.vld;
            r_c_item.vld <= r_b_item.vld;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item.pt  <= i_item.pt;
            r_a_item.box <= i_item.box;
            r_a_key      <= i_key;
            r_a_mag      <= n_a_mag;
            r_b_item.pt  <= r_a_item.pt;
            r_b_item.box <= r_a_item.box;
            r_b_key      <= r_a_key;
            for (int i = 0; i < 8; i++) begin
                r_b_sq[i] <= r_a_mag[i] * r_a_mag[i];
            end
            r_c_item.pt  <= r_b_item.pt;
            r_c_item.box <= n_box;
            r_c_key      <= {r_b_key[KEY_W-3:0], w_q};
        end
    end

    // sum squares, pick nearest corner, earlier corner wins a tie
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_dist[i] = {1'b0, r_b_sq[2*i]} + {1'b0, r_b_sq[2*i+1]};
        end
        if (w_dist[0] <= w_dist[1] && w_dist[0] <= w_dist[2] && w_dist[0] <= w_dist[3]) begin
            w_q = CA;
        end else if (w_dist[1] <= w_dist[2] && w_dist[1] <= w_dist[3]) begin
            w_q = CB;
        end else if (w_dist[2] <= w_dist[3]) begin
            w_q = CC;
        end else begin
            w_q = CD;
        end
    end

    // rebuild the sub-box from corner midpoints
    always_comb begin
        w_ab = f_pmid(r_b_item.box[CA], r_b_item.box[CB]);
        w_ac = f_pmid(r_b_item.box[CA], r_b_item.box[CC]);
        w_ad = f_pmid(r_b_item.box[CA], r_b_item.box[CD]);
        w_bc = f_pmid(r_b_item.box[CB], r_b_item.box[CC]);
        w_bd = f_pmid(r_b_item.box[CB], r_b_item.box[CD]);
        w_cd = f_pmid(r_b_item.box[CC], r_b_item.box[CD]);
        case (w_q)
            CA: begin
                n_box[CA] = r_b_item.box[CA];
                n_box[CB] = w_ad;
                n_box[CC] = w_ac;
                n_box[CD] = w_ab;
            end
            CB: begin
                n_box[CA] = w_ab;
                n_box[CB] = r_b_item.box[CB];
                n_box[CC] = w_bc;
                n_box[CD] = w_bd;
            end
            CC: begin
                n_box[CA] = w_ac;
                n_box[CB] = w_bc;
                n_box[CC] = r_b_item.box[CC];
                n_box[CD] = w_cd;
            end
            default: begin
                n_box[CA] = w_cd;
                n_box[CB] = w_bd;
                n_box[CC] = w_ad;
                n_box[CD] = r_b_item.box[CD];
            end
        endcase
    end

    assign o_item = r_c_item;
    assign o_key  = r_c_key;

    // winning corner survives into the new box
    a_keep_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_b_item.vld |=> r_c_item.box[r_c_key[1:0]] == $past(r_b_item.box[w_q]))
        else $error("winning corner not kept");

    // key bits just added name the winning corner
    a_key_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_c_key[1:0] == $past(w_q))
        else $error("key bits do not match nearest corner");

    // valid moves one stage per enabled cycle
    a_vld_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_c_item.vld == $past(r_b_item.vld) && r_b_item.vld == $past(r_a_item.vld))
        else $error("valid lost between stages");

endmodule
`default_nettype wire
